// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge
`define ELV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("elv: check failed");

// Antecedent at one edge implies consequent at the next edge
`define ELV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elv: sequence check failed");

`endif

// ===== design/elv_pkg.sv =====
// ---------------------------------------------------------------------------
// elv_pkg
// Types, register names, microcode and tables for the look-at view matrix unit.
// ---------------------------------------------------------------------------
package elv_pkg;

  localparam int VW = 40;            // working register width
  localparam int MW = 34;            // multiplier operand width
  localparam int CW = 34;            // CORDIC datapath width
  localparam int LW = 33;            // vector length width
  localparam int QW = 31;            // normalized quotient width
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS = 32;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [MW-1:0] ONE30 = 34'sd1073741824;
  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic signed [VW-1:0] val_t;

  // Working registers of the engine; R_ONE is the constant 1.0 in Q30
  typedef enum logic [4:0] {
    R_SP, R_CP, R_SY, R_CY, R_SR, R_CR,
    R_PX, R_PY, R_PZ, R_T,
    R_U0, R_U1, R_U2,
    R_F0, R_F1, R_F2,
    R_X0, R_X1, R_X2,
    R_Y0, R_Y1, R_Y2,
    R_D0, R_D1, R_D2,
    R_ONE
  } reg_id_t;

  localparam int NREG = 25;

  typedef enum logic [2:0] {
    OP_MUL, OP_MAC, OP_MSUB, OP_SQ0, OP_SQACC, OP_SQRT, OP_DIV, OP_DONE
  } op_t;

  typedef struct packed {
    op_t     op;
    reg_id_t dst;
    reg_id_t srca;
    reg_id_t srcb;
    logic    nega;
  } uop_t;

  // One queued camera update, angles already turned into the right half plane
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] turn;
    logic [2:0]       flip;
  } item_t;

  // Finished axes and dot sums handed to the row emitter
  typedef struct packed {
    val_t [2:0] ax;
    val_t [2:0] ay;
    val_t [2:0] fz;
    val_t [2:0] dot;
  } result_t;

  function automatic uop_t mk(op_t op, reg_id_t d, reg_id_t a, reg_id_t b, logic n);
    uop_t u;
    u.op = op;
    u.dst = d;
    u.srca = a;
    u.srcb = b;
    u.nega = n;
    return u;
  endfunction

  // Engine program
  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t u;
    unique case (pc)
      // forward vector and up vector
      6'd0:  u = mk(OP_MUL,  R_F0, R_CP, R_SY, 1'b0);
      6'd1:  u = mk(OP_MUL,  R_F1, R_SP, R_ONE, 1'b1);
      6'd2:  u = mk(OP_MUL,  R_F2, R_CP, R_CY, 1'b0);
      6'd3:  u = mk(OP_MUL,  R_T,  R_CR, R_SP, 1'b0);
      6'd4:  u = mk(OP_MUL,  R_U0, R_SR, R_CY, 1'b1);
      6'd5:  u = mk(OP_MAC,  R_U0, R_T,  R_SY, 1'b0);
      6'd6:  u = mk(OP_MUL,  R_U1, R_CR, R_CP, 1'b0);
      6'd7:  u = mk(OP_MUL,  R_U2, R_SR, R_SY, 1'b0);
      6'd8:  u = mk(OP_MAC,  R_U2, R_T,  R_CY, 1'b0);
      // normalize z
      6'd9:  u = mk(OP_SQ0,   R_SP, R_F0, R_F0, 1'b0);
      6'd10: u = mk(OP_SQACC, R_SP, R_F1, R_F1, 1'b0);
      6'd11: u = mk(OP_SQACC, R_SP, R_F2, R_F2, 1'b0);
      6'd12: u = mk(OP_SQRT,  R_SP, R_SP, R_SP, 1'b0);
      6'd13: u = mk(OP_DIV,   R_F0, R_F0, R_SP, 1'b0);
      6'd14: u = mk(OP_DIV,   R_F1, R_F1, R_SP, 1'b0);
      6'd15: u = mk(OP_DIV,   R_F2, R_F2, R_SP, 1'b0);
      // x = up cross z
      6'd16: u = mk(OP_MUL,  R_X0, R_U1, R_F2, 1'b0);
      6'd17: u = mk(OP_MSUB, R_X0, R_U2, R_F1, 1'b0);
      6'd18: u = mk(OP_MUL,  R_X1, R_U2, R_F0, 1'b0);
      6'd19: u = mk(OP_MSUB, R_X1, R_U0, R_F2, 1'b0);
      6'd20: u = mk(OP_MUL,  R_X2, R_U0, R_F1, 1'b0);
      6'd21: u = mk(OP_MSUB, R_X2, R_U1, R_F0, 1'b0);
      // normalize x
      6'd22: u = mk(OP_SQ0,   R_SP, R_X0, R_X0, 1'b0);
      6'd23: u = mk(OP_SQACC, R_SP, R_X1, R_X1, 1'b0);
      6'd24: u = mk(OP_SQACC, R_SP, R_X2, R_X2, 1'b0);
      6'd25: u = mk(OP_SQRT,  R_SP, R_SP, R_SP, 1'b0);
      6'd26: u = mk(OP_DIV,   R_X0, R_X0, R_SP, 1'b0);
      6'd27: u = mk(OP_DIV,   R_X1, R_X1, R_SP, 1'b0);
      6'd28: u = mk(OP_DIV,   R_X2, R_X2, R_SP, 1'b0);
      // y = z cross x
      6'd29: u = mk(OP_MUL,  R_Y0, R_F1, R_X2, 1'b0);
      6'd30: u = mk(OP_MSUB, R_Y0, R_F2, R_X1, 1'b0);
      6'd31: u = mk(OP_MUL,  R_Y1, R_F2, R_X0, 1'b0);
      6'd32: u = mk(OP_MSUB, R_Y1, R_F0, R_X2, 1'b0);
      6'd33: u = mk(OP_MUL,  R_Y2, R_F0, R_X1, 1'b0);
      6'd34: u = mk(OP_MSUB, R_Y2, R_F1, R_X0, 1'b0);
      // dot products with the position
      6'd35: u = mk(OP_MUL,  R_D0, R_X0, R_PX, 1'b0);
      6'd36: u = mk(OP_MAC,  R_D0, R_X1, R_PY, 1'b0);
      6'd37: u = mk(OP_MAC,  R_D0, R_X2, R_PZ, 1'b0);
      6'd38: u = mk(OP_MUL,  R_D1, R_Y0, R_PX, 1'b0);
      6'd39: u = mk(OP_MAC,  R_D1, R_Y1, R_PY, 1'b0);
      6'd40: u = mk(OP_MAC,  R_D1, R_Y2, R_PZ, 1'b0);
      6'd41: u = mk(OP_MUL,  R_D2, R_F0, R_PX, 1'b0);
      6'd42: u = mk(OP_MAC,  R_D2, R_F1, R_PY, 1'b0);
      6'd43: u = mk(OP_MAC,  R_D2, R_F2, R_PZ, 1'b0);
      default: u = mk(OP_DONE, R_SP, R_SP, R_SP, 1'b0);
    endcase
    return u;
  endfunction

  // CORDIC arctangent table in 32-bit turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== design/elv_front.sv =====
// ---------------------------------------------------------------------------
// elv_front
// Input side: unpacks a camera word and reduces each angle to a CORDIC turn.
// ---------------------------------------------------------------------------
module elv_front import elv_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // pos_x, pos_y, pos_z, angle_pitch, angle_yaw, angle_roll
  input  logic         q_full,
  output logic         q_push,
  output item_t        q_item
);

  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  assign s_tready = !q_full;
  assign q_push = s_tvalid && !q_full;

  // angles outside +-90 degrees are turned by half a turn and flagged
  always_comb begin
    logic [31:0] t;
    for (int k = 0; k < 3; k++) begin
      q_item.pos[k] = s_tdata[32*k +: 32];
      t = ({16'b0, s_tdata[96 + 16*k +: 16]} & ANG_MASK) << (32 - ANGLE_BITS);
      q_item.flip[k] = t[31] ^ t[30];
      q_item.turn[k] = q_item.flip[k] ? (t ^ 32'h80000000) : t;
    end
  end

endmodule

// ===== design/elv_queue.sv =====
// ---------------------------------------------------------------------------
// elv_queue
// Two-entry queue between the input side and the engine.
// ---------------------------------------------------------------------------
module elv_queue import elv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output item_t head
);

  item_t       mem [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;

  assign full = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign head = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

endmodule

// ===== design/elv_cordic.sv =====
// ---------------------------------------------------------------------------
// elv_cordic
// Iterative rotation-mode CORDIC, one step per cycle, giving sine and cosine.
// ---------------------------------------------------------------------------
module elv_cordic import elv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          turn,
  input  logic                 flip,
  output logic                 busy,
  output logic signed [CW-1:0] sin_q,
  output logic signed [CW-1:0] cos_q
);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic [4:0]           step;
  logic                 flip_r;
  logic signed [CW-1:0] at;

  assign at = CW'(atan_turn(step));
  assign sin_q = flip_r ? -y : y;
  assign cos_q = flip_r ? -x : x;

  // micro-rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 5'd0;
      flip_r <= flip;
      x <= CORDIC_X0;
      y <= '0;
      z <= CW'(signed'(turn));
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - (y >>> step);
        y <= y + (x >>> step);
        z <= z - at;
      end else begin
        x <= x + (y >>> step);
        y <= y - (x >>> step);
        z <= z + at;
      end
      step <= step + 5'd1;
      if (step == 5'(CORDIC_STEPS - 1)) busy <= 1'b0;
    end
  end

endmodule

// ===== design/elv_engine.sv =====
// ---------------------------------------------------------------------------
// elv_engine
// Back end: trig lanes, then a small program on one multiplier, a square
// root unit and a divider that builds the view axes and dot sums.
// ---------------------------------------------------------------------------
module elv_engine import elv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [2:0] {
    E_IDLE, E_TRIG, E_ISSUE, E_WB, E_SQRT, E_DIV, E_DONE
  } state_t;

  state_t              state;
  logic [5:0]          pc;
  val_t                vr [NREG];
  uop_t                uc;
  logic                trig_start;
  logic [2:0]          trig_busy;
  logic signed [CW-1:0] sin_v [3];
  logic signed [CW-1:0] cos_v [3];

  // multiplier
  logic signed [MW-1:0]   opa;
  logic signed [MW-1:0]   opb;
  logic signed [2*MW-1:0] mprod;
  logic signed [2*MW-1:0] prod;
  logic signed [2*MW-1:0] rnd;
  val_t                   mres;

  // square root and divider
  logic [63:0]  len2;
  logic [LW-1:0] len;
  logic [63:0]  sq_v;
  logic [63:0]  sq_r;
  logic [63:0]  sq_bit;
  logic [63:0]  sq_sum;
  logic [63:0]  sq_r_next;
  logic [4:0]   cnt;
  logic [LW-1:0] rem;
  logic [QW-1:0] nlow;
  logic [QW-1:0] quo;
  logic         qneg;
  logic [LW:0]  trial;
  logic         tge;
  val_t         amag;
  logic [63:0]  num;
  val_t         qval;

  assign uc = ucode(pc);
  assign trig_start = (state == E_IDLE) && q_valid;
  assign q_pop = trig_start;
  assign res_valid = (state == E_DONE);

  // three trig lanes, one per angle
  for (genvar k = 0; k < 3; k++) begin : g_trig
    elv_cordic u_cordic (
      .clk   (clk),
      .rst   (rst),
      .start (trig_start),
      .turn  (q_item.turn[k]),
      .flip  (q_item.flip[k]),
      .busy  (trig_busy[k]),
      .sin_q (sin_v[k]),
      .cos_q (cos_v[k])
    );
  end

  // operand select and product
  assign opa = (uc.srca == R_ONE) ? ONE30 : vr[uc.srca][MW-1:0];
  assign opb = (uc.srcb == R_ONE) ? ONE30 : vr[uc.srcb][MW-1:0];
  assign mprod = uc.nega ? -(opa * opb) : (opa * opb);
  assign rnd = prod + ((2*MW)'(1) <<< 29);
  assign mres = VW'(rnd >>> 30);

  // square root step
  assign sq_sum = sq_r + sq_bit;
  assign sq_r_next = (sq_v >= sq_sum) ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);

  // divide step
  assign trial = {rem, nlow[QW-1]};
  assign tge = (trial >= {1'b0, len});
  assign amag = vr[uc.srca][VW-1] ? -vr[uc.srca] : vr[uc.srca];
  assign num = {amag[MW-1:0], 30'b0};
  assign qval = qneg ? -val_t'({1'b0, quo[QW-2:0], tge})
                     : val_t'({1'b0, quo[QW-2:0], tge});

  // results for the row emitter
  assign res.ax = {vr[R_X2], vr[R_X1], vr[R_X0]};
  assign res.ay = {vr[R_Y2], vr[R_Y1], vr[R_Y0]};
  assign res.fz = {vr[R_F2], vr[R_F1], vr[R_F0]};
  assign res.dot = {vr[R_D2], vr[R_D1], vr[R_D0]};

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      pc <= '0;
      cnt <= '0;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (q_valid) begin
            vr[R_PX] <= VW'(signed'(q_item.pos[0]));
            vr[R_PY] <= VW'(signed'(q_item.pos[1]));
            vr[R_PZ] <= VW'(signed'(q_item.pos[2]));
            state <= E_TRIG;
          end
        end
        E_TRIG: begin
          if (trig_busy == 3'b000) begin
            vr[R_SP] <= VW'(sin_v[0]);
            vr[R_CP] <= VW'(cos_v[0]);
            vr[R_SY] <= VW'(sin_v[1]);
            vr[R_CY] <= VW'(cos_v[1]);
            vr[R_SR] <= VW'(sin_v[2]);
            vr[R_CR] <= VW'(cos_v[2]);
            pc <= '0;
            state <= E_ISSUE;
          end
        end
        E_ISSUE: begin
          unique case (uc.op)
            OP_MUL, OP_MAC, OP_MSUB, OP_SQ0, OP_SQACC: begin
              prod <= mprod;
              state <= E_WB;
            end
            OP_SQRT: begin
              sq_v <= len2;
              sq_r <= '0;
              sq_bit <= 64'd1 << 62;
              cnt <= '0;
              state <= E_SQRT;
            end
            OP_DIV: begin
              if (len == '0) begin
                vr[uc.dst] <= '0;
                pc <= pc + 6'd1;
              end else begin
                qneg <= vr[uc.srca][VW-1];
                rem <= num[63:64-LW];
                nlow <= num[QW-1:0];
                quo <= '0;
                cnt <= '0;
                state <= E_DIV;
              end
            end
            default: begin
              state <= E_DONE;
            end
          endcase
        end
        E_WB: begin
          unique case (uc.op)
            OP_MUL:   vr[uc.dst] <= mres;
            OP_MAC:   vr[uc.dst] <= vr[uc.dst] + mres;
            OP_MSUB:  vr[uc.dst] <= vr[uc.dst] - mres;
            OP_SQ0:   len2 <= prod[63:0];
            default:  len2 <= len2 + prod[63:0];
          endcase
          pc <= pc + 6'd1;
          state <= E_ISSUE;
        end
        E_SQRT: begin
          if (sq_v >= sq_sum) sq_v <= sq_v - sq_sum;
          sq_r <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(SQRT_STEPS - 1)) begin
            len <= sq_r_next[LW-1:0];
            pc <= pc + 6'd1;
            state <= E_ISSUE;
          end
        end
        E_DIV: begin
          rem <= tge ? LW'(trial - {1'b0, len}) : trial[LW-1:0];
          nlow <= nlow << 1;
          quo <= {quo[QW-2:0], tge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QW - 1)) begin
            vr[uc.dst] <= qval;
            pc <= pc + 6'd1;
            state <= E_ISSUE;
          end
        end
        default: begin
          if (res_ready) state <= E_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/elv_out.sv =====
// ---------------------------------------------------------------------------
// elv_out
// Row emitter: rounds and saturates a finished matrix into four row words.
// ---------------------------------------------------------------------------
module elv_out import elv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         res_valid,
  output logic         res_ready,
  input  result_t      res,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,  // row_index, elem_0, elem_1, elem_2, elem_3
  output logic         m_tlast   // last_row
);

  localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
  localparam val_t RND_Q = val_t'(1) <<< (29 - FRAC_BITS);

  logic [2:0][31:0] rows [4];
  logic             busy;
  logic [1:0]       row;
  logic [31:0]      elem3;

  function automatic logic [31:0] sat32(input val_t v);
    logic [31:0] r;
    if (v > val_t'(64'sd2147483647)) r = 32'h7FFFFFFF;
    else if (v < val_t'(-64'sd2147483648)) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] to_q(input val_t v);
    val_t s;
    s = (v + RND_Q) >>> (30 - FRAC_BITS);
    return sat32(s);
  endfunction

  assign res_ready = !busy || (m_tready && row == LAST_ROW);
  assign m_tvalid = busy;
  assign m_tlast = (row == LAST_ROW);
  assign elem3 = (row == LAST_ROW) ? ONE_Q : 32'd0;
  assign m_tdata = {6'b0, elem3, rows[row][2], rows[row][1], rows[row][0], row};

  // row storage, filled with the converted matrix
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      for (int i = 0; i < 3; i++) begin
        rows[i][0] <= to_q(res.ax[i]);
        rows[i][1] <= to_q(res.ay[i]);
        rows[i][2] <= to_q(res.fz[i]);
      end
      for (int k = 0; k < 3; k++) begin
        rows[3][k] <= sat32(-res.dot[k]);
      end
    end
  end

  // row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row <= 2'd0;
    end else begin
      if (m_tvalid && m_tready) begin
        row <= row + 2'd1;
        if (row == LAST_ROW) busy <= 1'b0;
      end
      if (res_valid && res_ready) begin
        busy <= 1'b1;
        row <= 2'd0;
      end
    end
  end

endmodule

// ===== design/euler_lookat_view_matrix_unit.sv =====
// ---------------------------------------------------------------------------
// euler_lookat_view_matrix_unit
// Left-handed look-at view matrix from a camera position and pitch/yaw/roll.
// ---------------------------------------------------------------------------
// Each input word carries a camera position (Q.FRAC_BITS) and three binary
// angles; the unit answers with four output words, matrix rows 0 to 3, the
// last one flagged by tlast. For one camera update the engine runs 30 CORDIC
// steps for the three angles in parallel, 36 multiplies on the single shared
// multiplier, two 32-step square roots and six 31-step divides for the two
// normalizations. A two-entry queue takes new words while the engine works,
// and the row emitter drains the previous matrix while the engine computes
// the next one.
`include "assert_macros.svh"

module euler_lookat_view_matrix_unit import elv_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // pos_x, pos_y, pos_z, angle_pitch, angle_yaw, angle_roll
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,  // row_index, elem_0, elem_1, elem_2, elem_3, zero pad
  output logic         m_tlast   // last_row
);

  logic    q_full;
  logic    q_push;
  item_t   q_in;
  logic    q_valid;
  logic    q_pop;
  item_t   q_head;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  elv_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  elv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  elv_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  elv_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // tlast marks row three only
  `ELV_ASSERT(a_last_is_row3, !(m_tvalid && m_tlast) || (m_tdata[1:0] == LAST_ROW))
  // a matrix is emitted without gaps once started
  `ELV_ASSERT_NEXT(a_rows_continue, m_tvalid && m_tready && !m_tlast, m_tvalid)
  // the next matrix starts again at row zero
  `ELV_ASSERT_NEXT(a_restart_row0, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tdata[1:0] == 2'd0))

endmodule

// ===== bench/euler_lookat_view_matrix_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_lookat_view_matrix_unit_tb
// Self-checking bench: camera updates in, four view-matrix rows out, each row
// compared with a bit-exact software model of CORDIC, normalize and cross.
// ---------------------------------------------------------------------------
module euler_lookat_view_matrix_unit_tb;

  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_BITS = 16;
  localparam int N_RANDOM   = 170;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;

  typedef struct packed {
    logic [1:0]  row;
    logic [31:0] e0, e1, e2, e3;
    logic        last;
  } row_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] ap, ay, ar;
    logic        has_exp;
    logic [31:0] exp_e3;
  } stim_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         m_tlast;

  row_t   row_q[$];
  stim_t  dir_tab[$];
  int     n_err = 0;
  int     n_rows = 0;
  int     n_words = 0;
  int     idle_cnt = 0;
  bit     long_hold = 1'b0;
  bit     done = 1'b0;

  euler_lookat_view_matrix_unit #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- arithmetic helpers ----
  function automatic logic signed [63:0] asr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] mul_q30(logic signed [63:0] a, logic signed [63:0] b);
    return asr(a * b + (Q30_ONE >>> 1), 30);
  endfunction

  function automatic logic signed [63:0] sat(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] atan_lut(int i);
    logic [31:0] t[30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    return t[i];
  endfunction

  task automatic cordic(input logic [15:0] ang, output logic signed [63:0] s,
                        output logic signed [63:0] c);
    logic [31:0] t;
    logic flip;
    logic signed [63:0] x, y, z, dx, dy;
    t = 32'(ang) << (32 - ANGLE_BITS);
    flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
    if (flip) t = t - 32'h80000000;
    x = 64'sd652032874;
    y = 0;
    z = 64'(signed'(t));
    for (int i = 0; i < 30; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - 64'(atan_lut(i));
      end else begin
        x = x + dx; y = y - dy; z = z + 64'(atan_lut(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic norm(inout logic signed [63:0] v[3]);
    logic [63:0] l2;
    logic signed [63:0] len;
    l2 = 64'(v[0] * v[0]) + 64'(v[1] * v[1]) + 64'(v[2] * v[2]);
    len = signed'(isqrt(l2));
    for (int i = 0; i < 3; i++) v[i] = (len == 0) ? 64'sd0 : (v[i] * Q30_ONE) / len;
  endtask

  task automatic cross3(input logic signed [63:0] a[3], input logic signed [63:0] b[3],
                        output logic signed [63:0] r[3]);
    r[0] = mul_q30(a[1], b[2]) - mul_q30(a[2], b[1]);
    r[1] = mul_q30(a[2], b[0]) - mul_q30(a[0], b[2]);
    r[2] = mul_q30(a[0], b[1]) - mul_q30(a[1], b[0]);
  endtask

  function automatic logic [31:0] to_fix(logic signed [63:0] v);
    return 32'(sat(asr(v + (64'sd1 <<< (29 - FRAC_BITS)), 30 - FRAC_BITS)));
  endfunction

  function automatic logic [31:0] neg_dot(logic signed [63:0] a[3], logic signed [63:0] p[3]);
    logic signed [63:0] sum;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += asr(a[i] * p[i] + (Q30_ONE >>> 1), 30);
    return 32'(sat(-sum));
  endfunction

  // Predict the four view-matrix rows of one camera update
  task automatic predict_view_rows(input stim_t st);
    logic signed [63:0] p[3], fz[3], up[3], ax[3], ay[3];
    logic signed [63:0] sp, cp, sy, cy, sr, cr;
    row_t r;
    p[0] = 64'(signed'(st.px));
    p[1] = 64'(signed'(st.py));
    p[2] = 64'(signed'(st.pz));
    cordic(st.ap, sp, cp);
    cordic(st.ay, sy, cy);
    cordic(st.ar, sr, cr);
    fz[0] = mul_q30(cp, sy);
    fz[1] = -sp;
    fz[2] = mul_q30(cp, cy);
    up[0] = mul_q30(-sr, cy) + mul_q30(mul_q30(cr, sp), sy);
    up[1] = mul_q30(cr, cp);
    up[2] = mul_q30(sr, sy) + mul_q30(mul_q30(cr, sp), cy);
    norm(fz);
    cross3(up, fz, ax);
    norm(ax);
    cross3(fz, ax, ay);
    for (int i = 0; i < 3; i++) begin
      r.row = 2'(i);
      r.e0 = to_fix(ax[i]);
      r.e1 = to_fix(ay[i]);
      r.e2 = to_fix(fz[i]);
      r.e3 = 32'd0;
      r.last = 1'b0;
      if (st.has_exp) r.e3 = st.exp_e3;
      row_q.push_back(r);
    end
    r.row = 2'd3;
    r.e0 = neg_dot(ax, p);
    r.e1 = neg_dot(ay, p);
    r.e2 = neg_dot(fz, p);
    r.e3 = 32'd1 << FRAC_BITS;
    r.last = 1'b1;
    row_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH row word %0d %s: got %h want %h", n_rows, what, got, want);
    n_err++;
  endtask

  function automatic stim_t mk_stim(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [15:0] p, logic [15:0] w, logic [15:0] r);
    stim_t s;
    s.px = x; s.py = y; s.pz = z; s.ap = p; s.ay = w; s.ar = r;
    s.has_exp = 1'b1;
    s.exp_e3 = 32'd0;
    return s;
  endfunction

  function automatic stim_t rand_stim();
    stim_t s;
    int k;
    k = $urandom_range(0, 9);
    s.px = $urandom; s.py = $urandom; s.pz = $urandom;
    // mostly modest positions, sometimes full range to hit saturation
    if (k < 7) begin
      s.px = 32'(signed'($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
      s.py = 32'(signed'($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
      s.pz = 32'(signed'($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
    end
    s.ap = 16'($urandom); s.ay = 16'($urandom); s.ar = 16'($urandom);
    if (k == 9) s.ap = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
    s.has_exp = 1'b0;
    s.exp_e3 = 32'd0;
    return s;
  endfunction

  // ---- output check ----
  always @(posedge clk) begin
    row_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = row_t'({m_tdata[1:0], m_tdata[33:2], m_tdata[65:34],
                    m_tdata[97:66], m_tdata[129:98], m_tlast});
      if (row_q.size() == 0) begin
        report("unexpected row", 32'd0, 32'd0);
      end else begin
        want = row_q.pop_front();
        if (got.row != want.row) report("row_index", 32'(got.row), 32'(want.row));
        if (got.e0 != want.e0) report("elem_0", got.e0, want.e0);
        if (got.e1 != want.e1) report("elem_1", got.e1, want.e1);
        if (got.e2 != want.e2) report("elem_2", got.e2, want.e2);
        if (got.e3 != want.e3) report("elem_3", got.e3, want.e3);
        if (got.last != want.last) report("last_row", 32'(got.last), 32'(want.last));
        if (m_tdata[135:130] != '0) report("pad", 32'(m_tdata[135:130]), 32'd0);
      end
      n_rows++;
    end
  end

  // ---- receiver stall pattern ----
  always @(posedge clk) begin
    int hold;
    if (rst) m_tready <= 1'b0;
    else if (long_hold) begin
      m_tready <= 1'b0;
      for (hold = 0; hold < 3000; hold++) @(posedge clk);
      long_hold = 1'b0;
    end else if (n_words < 40) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT && !done) begin
      $display("euler_lookat_view_matrix_unit test failed");
      $finish;
    end
  end

  task automatic send_word(input stim_t st, input bit gappy);
    if (gappy && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {st.ar, st.ay, st.ap, st.pz, st.py, st.px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_view_rows(st);
    n_words++;
  endtask

  initial begin
    stim_t st;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero angles, extreme positions, quadrant edges, wrap
    dir_tab.push_back(mk_stim(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
    dir_tab.push_back(mk_stim(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0, 16'd0, 16'd0));
    dir_tab.push_back(mk_stim(32'h80000000, 32'h80000000, 32'h80000000, 16'd0, 16'd0, 16'd0));
    dir_tab.push_back(mk_stim(32'h00010000, 32'hFFFF0000, 32'h00020000,
                              16'hFFFF, 16'hFFFF, 16'hFFFF));
    dir_tab.push_back(mk_stim(32'd0, 32'd0, 32'd0, 16'h4000, 16'd0, 16'd0));
    dir_tab.push_back(mk_stim(32'd0, 32'd0, 32'd0, 16'hC000, 16'd0, 16'd0));
    dir_tab.push_back(mk_stim(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                              16'h8000, 16'h8000, 16'h8000));
    dir_tab.push_back(mk_stim(32'h12345678, 32'h87654321, 32'h0F0F0F0F,
                              16'h2000, 16'h6000, 16'hA000));
    dir_tab.push_back(mk_stim(32'h00000001, 32'hFFFFFFFF, 32'h55555555,
                              16'h3FFF, 16'h4001, 16'hBFFF));
    dir_tab.push_back(mk_stim(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                              16'h5555, 16'hAAAA, 16'h5555));
    foreach (dir_tab[i]) send_word(dir_tab[i], 1'b0);

    // random phase with bursts, a long receiver hold and a drain pause
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 30) long_hold = 1'b1;
      if (i == 90) begin
        s_tvalid <= 1'b0;
        while (row_q.size() != 0) @(posedge clk);
      end
      st = rand_stim();
      send_word(st, i > 10);
    end
    s_tvalid <= 1'b0;

    while (row_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    done = 1'b1;
    $display("Covered %0d camera updates, %0d rows: extreme positions, quadrant edges,",
             n_words, n_rows);
    $display("random angles with input backpressure and output stalls.");
    if (n_err == 0) $display("euler_lookat_view_matrix_unit test passed");
    else $display("euler_lookat_view_matrix_unit test failed");
    $finish;
  end

endmodule
